// ===== sv/tod_pkg.sv =====
// Shared types, register offsets and function codes for the time-of-day counter.
`timescale 1ns / 1ps
`default_nettype none

package tod_pkg;

    localparam int SEC_W    = 48;
    localparam int NS_W     = 30;
    localparam int PERIOD_W = 20;
    localparam int DRIFT_W  = 16;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 9;
    localparam int FUNC_W   = 2;

    // Function codes of an input item.
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    // Register byte offsets.
    localparam logic [ADDR_W-1:0] REG_CLOCK      = 9'h038;
    localparam logic [ADDR_W-1:0] REG_SEC_HI     = 9'h100;
    localparam logic [ADDR_W-1:0] REG_SEC_LO     = 9'h104;
    localparam logic [ADDR_W-1:0] REG_NS         = 9'h108;
    localparam logic [ADDR_W-1:0] REG_PERIOD     = 9'h110;
    localparam logic [ADDR_W-1:0] REG_ADJ_PERIOD = 9'h114;
    localparam logic [ADDR_W-1:0] REG_ADJ_COUNT  = 9'h118;
    localparam logic [ADDR_W-1:0] REG_DRIFT      = 9'h11c;
    localparam logic [ADDR_W-1:0] REG_DRIFT_RATE = 9'h120;

    localparam logic [NS_W-1:0]   NS_PER_SEC     = 30'd1000000000;
    localparam logic [NS_W-1:0]   NS_MAX         = 30'd999999999;
    localparam logic [DATA_W-1:0] CLOCK_HZ_RESET = 32'd250000000;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } item_t;

    typedef struct packed {
        logic [DATA_W-1:0] rdata;
        logic [SEC_W-1:0]  seconds;
        logic [NS_W-1:0]   nanoseconds;
        logic              adjusting;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/tod_in_stage.sv =====
// Input register stage that holds one accepted item until the core takes it.
`timescale 1ns / 1ps
`default_nettype none

module tod_in_stage
    import tod_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire item_t  s_item,
    input  wire         take,
    output logic        item_valid,
    output item_t       item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // The stage refills in the same cycle that the core takes its item.
    assign s_ready    = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

`default_nettype wire

// ===== sv/tod_core.sv =====
// Time-of-day state registers with the tick, register write and register read logic.
`timescale 1ns / 1ps
`default_nettype none

module tod_core
    import tod_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                cfg_we,
    input  wire [DATA_W-1:0]   cfg_data,
    input  wire                fire,
    input  wire item_t         item,
    output result_t            result
);

    localparam int INC_W   = PERIOD_W + 1;
    localparam int SUM_W   = ((FRACTION_BITS > INC_W) ? FRACTION_BITS : INC_W) + 1;
    localparam int CARRY_W = SUM_W - FRACTION_BITS;
    localparam int NSX_W   = NS_W + 1;

    logic [DATA_W-1:0]        clock_hz_reg;
    logic [SEC_W-1:0]         sec_reg, sec_next;
    logic [NS_W-1:0]          ns_reg, ns_next;
    logic [FRACTION_BITS-1:0] frac_reg, frac_next;
    logic [SEC_W-1:0]         snap_reg, snap_next;
    logic [PERIOD_W-1:0]      period_reg, period_next;
    logic [PERIOD_W-1:0]      adj_period_reg, adj_period_next;
    logic [PERIOD_W-1:0]      adj_count_reg, adj_count_next;
    logic [DRIFT_W-1:0]       drift_reg, drift_next;
    logic [DRIFT_W-1:0]       drift_rate_reg, drift_rate_next;
    logic [DRIFT_W-1:0]       drift_ticks_reg, drift_ticks_next;

    logic [PERIOD_W-1:0]      inc_base;
    logic                     drift_hit;
    logic [INC_W-1:0]         inc;
    logic [SUM_W-1:0]         sum;
    logic [CARRY_W-1:0]       carry;
    logic [NSX_W-1:0]         ns_sum;
    logic                     wrap;
    logic [DATA_W-1:0]        rdata;

    // Tick datapath: one add into the fraction, one add and compare on nanoseconds.
    always_comb begin
        inc_base  = (adj_count_reg != '0) ? adj_period_reg : period_reg;
        drift_hit = (drift_rate_reg != '0) &&
                    ({1'b0, drift_ticks_reg} + 17'd1 >= {1'b0, drift_rate_reg});
        inc       = {1'b0, inc_base} +
                    (drift_hit ? INC_W'(drift_reg) : INC_W'(0));
        sum       = SUM_W'(frac_reg) + SUM_W'(inc);
        carry     = sum[SUM_W-1:FRACTION_BITS];
        ns_sum    = {1'b0, ns_reg} + NSX_W'(carry);
        wrap      = ns_sum >= {1'b0, NS_PER_SEC};
    end

    always_comb begin
        sec_next         = sec_reg;
        ns_next          = ns_reg;
        frac_next        = frac_reg;
        snap_next        = snap_reg;
        period_next      = period_reg;
        adj_period_next  = adj_period_reg;
        adj_count_next   = adj_count_reg;
        drift_next       = drift_reg;
        drift_rate_next  = drift_rate_reg;
        drift_ticks_next = drift_ticks_reg;
        rdata            = '0;

        unique case (item.func)
            FUNC_TICK: begin
                if (adj_count_reg != '0) begin
                    adj_count_next = adj_count_reg - 1'b1;
                end
                if (drift_rate_reg == '0 || drift_hit) begin
                    drift_ticks_next = '0;
                end else begin
                    drift_ticks_next = drift_ticks_reg + 1'b1;
                end
                frac_next = sum[FRACTION_BITS-1:0];
                if (wrap) begin
                    ns_next  = NS_W'(ns_sum - {1'b0, NS_PER_SEC});
                    sec_next = sec_reg + 1'b1;
                end else begin
                    ns_next = ns_sum[NS_W-1:0];
                end
            end
            FUNC_WRITE: begin
                unique case (item.addr)
                    REG_SEC_HI:     sec_next = {item.wdata[SEC_W-33:0], sec_reg[31:0]};
                    REG_SEC_LO:     sec_next = {sec_reg[SEC_W-1:32], item.wdata};
                    REG_NS: begin
                        // An out-of-range value pins to the last nanosecond.
                        if (item.wdata > {2'b00, NS_MAX}) begin
                            ns_next   = NS_MAX;
                            frac_next = '0;
                        end else begin
                            ns_next = item.wdata[NS_W-1:0];
                        end
                    end
                    REG_PERIOD:     period_next     = item.wdata[PERIOD_W-1:0];
                    REG_ADJ_PERIOD: adj_period_next = item.wdata[PERIOD_W-1:0];
                    REG_ADJ_COUNT:  adj_count_next  = item.wdata[PERIOD_W-1:0];
                    REG_DRIFT:      drift_next      = item.wdata[DRIFT_W-1:0];
                    REG_DRIFT_RATE: begin
                        drift_rate_next  = item.wdata[DRIFT_W-1:0];
                        drift_ticks_next = '0;
                    end
                    default: ;
                endcase
            end
            FUNC_READ: begin
                unique case (item.addr)
                    REG_CLOCK:      rdata = clock_hz_reg;
                    REG_SEC_HI:     rdata = DATA_W'(snap_reg[SEC_W-1:32]);
                    REG_SEC_LO:     rdata = snap_reg[31:0];
                    REG_NS: begin
                        // Reading nanoseconds freezes seconds for the following reads.
                        snap_next = sec_reg;
                        rdata     = DATA_W'(ns_reg);
                    end
                    REG_PERIOD:     rdata = DATA_W'(period_reg);
                    REG_ADJ_PERIOD: rdata = DATA_W'(adj_period_reg);
                    REG_ADJ_COUNT:  rdata = DATA_W'(adj_count_reg);
                    REG_DRIFT:      rdata = DATA_W'(drift_reg);
                    REG_DRIFT_RATE: rdata = DATA_W'(drift_rate_reg);
                    default:        rdata = '0;
                endcase
            end
            default: ;
        endcase
    end

    assign result = '{rdata:       rdata,
                      seconds:     sec_next,
                      nanoseconds: ns_next,
                      adjusting:   (adj_count_next != '0)};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_hz_reg    <= CLOCK_HZ_RESET;
            sec_reg         <= '0;
            ns_reg          <= '0;
            frac_reg        <= '0;
            snap_reg        <= '0;
            period_reg      <= '0;
            adj_period_reg  <= '0;
            adj_count_reg   <= '0;
            drift_reg       <= '0;
            drift_rate_reg  <= '0;
            drift_ticks_reg <= '0;
        end else begin
            if (cfg_we) begin
                clock_hz_reg <= cfg_data;
            end
            if (fire) begin
                sec_reg         <= sec_next;
                ns_reg          <= ns_next;
                frac_reg        <= frac_next;
                snap_reg        <= snap_next;
                period_reg      <= period_next;
                adj_period_reg  <= adj_period_next;
                adj_count_reg   <= adj_count_next;
                drift_reg       <= drift_next;
                drift_rate_reg  <= drift_rate_next;
                drift_ticks_reg <= drift_ticks_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/time_of_day_clock_with_adjust.sv =====
// Top level of the time-of-day counter: input stage, time core and result register.
// An accepted item is held in the input register, then passes through the core into the result register.
// Throughput: one item per cycle while the result channel is not stalled; the core is combinational.
// The result register and the input register let a new item enter while a result waits.
// Reset (aresetn low at a clock edge) clears the time, the core registers and the valid flags of both stages,
// and sets the reported clock frequency to 250 MHz.
`timescale 1ns / 1ps
`default_nettype none

module time_of_day_clock_with_adjust
    import tod_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  wire                aclk,
    input  wire                aresetn,
    // Configuration write channel: the clock frequency reported at the clock register.
    input  wire                cfg_valid,
    output logic               cfg_ready,
    input  wire [DATA_W-1:0]   cfg_data,
    // Item input channel.
    input  wire                s_valid,
    output logic               s_ready,
    input  wire [FUNC_W-1:0]   s_func,
    input  wire [ADDR_W-1:0]   s_addr,
    input  wire [DATA_W-1:0]   s_wdata,
    // Result channel.
    output logic               m_valid,
    input  wire                m_ready,
    output logic [DATA_W-1:0]  m_rdata,
    output logic [SEC_W-1:0]   m_now_seconds,
    output logic [NS_W-1:0]    m_now_nanoseconds,
    output logic               m_adjusting
);

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    fire;
    result_t result;
    result_t result_reg;
    logic    out_valid_reg;
    logic    out_valid_next;

    // The configuration register is always ready to be written.
    assign cfg_ready = 1'b1;

    assign s_item = '{func: s_func, addr: s_addr, wdata: s_wdata};

    // The core processes the held item whenever the result register is free or
    // is being emptied in this same cycle.
    assign fire = item_valid && (!out_valid_reg || m_ready);

    tod_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    tod_core #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .fire     (fire),
        .item     (item),
        .result   (result)
    );

    // Result register: loads on every processed item and holds while stalled.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            result_reg <= result;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_rdata           = result_reg.rdata;
    assign m_now_seconds     = result_reg.seconds;
    assign m_now_nanoseconds = result_reg.nanoseconds;
    assign m_adjusting       = result_reg.adjusting;

`ifndef SYNTH
    // Nanoseconds never reach a full second in any delivered result.
    a_ns_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_now_nanoseconds < NS_PER_SEC))
        else $error("nanoseconds out of range");

    // Ticks and writes return zero read data.
    a_rdata_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && item.func != FUNC_READ) |=> (m_rdata == '0))
        else $error("nonzero read data for a non-read item");

    // With both stages full and the output stalled, no further item is taken.
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid && out_valid_reg && !m_ready) |-> !s_ready)
        else $error("input accepted while both stages are full");
`endif

endmodule

`default_nettype wire
